// ----- rtl/rmq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_pkg: shared types, constants and saturating helpers
// Internal datapath words, slot codes and the sideband that travels with
// every transaction through the root and divider pipelines.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int unsigned IW        = 64;  // internal signed/unsigned word
  localparam int unsigned RW        = 32;  // square-root result width
  localparam int unsigned NUM_LANES = 3;   // quotient lanes

  typedef enum logic [1:0] {
    SLOT_X = 2'd0,
    SLOT_Y = 2'd1,
    SLOT_Z = 2'd2,
    SLOT_W = 2'd3
  } slot_e;

  typedef struct packed {
    logic                  degen;
    slot_e                 big;
    logic [NUM_LANES-1:0]  neg;
  } ctl_t;

  typedef struct packed {
    ctl_t                          ctl;
    logic [NUM_LANES-1:0][IW-1:0]  mag;
  } side_t;

  localparam logic [IW-1:0] SMAX = {1'b0, {(IW-1){1'b1}}};
  localparam logic [IW-1:0] SMIN = {1'b1, {(IW-1){1'b0}}};

  function automatic logic [IW-1:0] sat_add(input logic [IW-1:0] a,
                                            input logic [IW-1:0] b);
    logic [IW:0] s;
    s = {a[IW-1], a} + {b[IW-1], b};
    if (s[IW] != s[IW-1]) begin
      return s[IW] ? SMIN : SMAX;
    end
    return s[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] sat_neg(input logic [IW-1:0] a);
    return (a == SMIN) ? SMAX : (~a + {{(IW-1){1'b0}}, 1'b1});
  endfunction

  function automatic logic [IW-1:0] magnitude(input logic [IW-1:0] a);
    return a[IW-1] ? (~a + {{(IW-1){1'b0}}, 1'b1}) : a;
  endfunction

  function automatic logic [IW-1:0] sat_shl(input logic [IW-1:0] u,
                                            input int unsigned sh);
    logic [IW-1:0] lim;
    lim = {IW{1'b1}} >> sh;
    if (u > lim) begin
      return {IW{1'b1}};
    end
    return u << sh;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/rotation_matrix_to_quaternion.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion: fixed-point rotation matrix to quaternion
// Shoemake's method over a fully pipelined root and three dividers.
//
//   channel  | handshake          | payload
//   ---------+--------------------+--------------------------------------
//   input    | valid_i / stall_o  | m_0_i .. m_8_i (column-major matrix)
//   output   | valid_o / stall_i  | qx_o qy_o qz_o qw_o degenerate_o
//
// One transaction per cycle while no result is held at the output; the pipeline
// has 2 preparation stages, 32 square-root stages (one root bit each), 64
// divider stages (one quotient bit each) and the output register.
// Reset clears only the valid bits of every stage.
// A held result stalls the whole pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
  parameter int unsigned WORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 30
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          valid_i,
  output logic                         stall_o,
  input  wire  [WORD_WIDTH-1:0]        m_0_i,
  input  wire  [WORD_WIDTH-1:0]        m_1_i,
  input  wire  [WORD_WIDTH-1:0]        m_2_i,
  input  wire  [WORD_WIDTH-1:0]        m_3_i,
  input  wire  [WORD_WIDTH-1:0]        m_4_i,
  input  wire  [WORD_WIDTH-1:0]        m_5_i,
  input  wire  [WORD_WIDTH-1:0]        m_6_i,
  input  wire  [WORD_WIDTH-1:0]        m_7_i,
  input  wire  [WORD_WIDTH-1:0]        m_8_i,
  output logic                         valid_o,
  input  wire                          stall_i,
  output logic [WORD_WIDTH-1:0]        qx_o,
  output logic [WORD_WIDTH-1:0]        qy_o,
  output logic [WORD_WIDTH-1:0]        qz_o,
  output logic [WORD_WIDTH-1:0]        qw_o,
  output logic                         degenerate_o
);

  logic                                            en;
  logic [8:0][WORD_WIDTH-1:0]                      mat;
  logic                                            prep_vld;
  logic [rmq_pkg::IW-1:0]                          prep_rad;
  rmq_pkg::side_t                                  prep_side;
  logic                                            sq_vld;
  logic [rmq_pkg::RW-1:0]                          sq_root;
  rmq_pkg::side_t                                  sq_side;
  logic                                            dv_vld;
  logic [rmq_pkg::RW-1:0]                          dv_root;
  logic [rmq_pkg::NUM_LANES-1:0][rmq_pkg::IW-1:0]  dv_quot;
  rmq_pkg::ctl_t                                   dv_ctl;
  logic                                            out_vld;
  logic [3:0][WORD_WIDTH-1:0]                      out_q;

  // advance every stage unless a result is held at the output
  assign en      = !(out_vld && stall_i);
  assign stall_o = !en;

  assign mat = {m_8_i, m_7_i, m_6_i, m_5_i, m_4_i, m_3_i, m_2_i, m_1_i, m_0_i};

  rmq_prep #(
    .WORD_WIDTH (WORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_i),
    .mat_i   (mat),
    .valid_o (prep_vld),
    .rad_o   (prep_rad),
    .side_o  (prep_side)
  );

  rmq_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (prep_vld),
    .rad_i   (prep_rad),
    .side_i  (prep_side),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  rmq_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_vld),
    .root_i  (sq_root),
    .side_i  (sq_side),
    .valid_o (dv_vld),
    .root_o  (dv_root),
    .quot_o  (dv_quot),
    .ctl_o   (dv_ctl)
  );

  rmq_pack #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv_vld),
    .root_i  (dv_root),
    .quot_i  (dv_quot),
    .ctl_i   (dv_ctl),
    .valid_o (out_vld),
    .q_o     (out_q),
    .degen_o (degenerate_o)
  );

  assign valid_o = out_vld;
  assign qx_o    = out_q[rmq_pkg::SLOT_X];
  assign qy_o    = out_q[rmq_pkg::SLOT_Y];
  assign qz_o    = out_q[rmq_pkg::SLOT_Z];
  assign qw_o    = out_q[rmq_pkg::SLOT_W];

endmodule
`default_nettype wire

// ----- rtl/rmq_prep.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_prep: trace, branch selection and operand preparation
// Two register stages: sums and differences first, then radicand and
// scaled numerator magnitudes routed to the three quotient lanes.
// ----------------------------------------------------------------------------
module rmq_prep #(
  parameter int unsigned WORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 30
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              en_i,
  input  wire                              valid_i,
  input  wire  [8:0][WORD_WIDTH-1:0]       mat_i,
  output logic                             valid_o,
  output logic [rmq_pkg::IW-1:0]           rad_o,
  output rmq_pkg::side_t                   side_o
);

  localparam int unsigned IW = rmq_pkg::IW;
  localparam logic [IW-1:0] ONE = {{(IW-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam int unsigned SH = FRAC_BITS - 2;

  logic [IW-1:0] d [9];
  logic [1:0]    isel_d;

  // stage 1
  logic          vld1_q;
  logic [IW-1:0] trace_q;
  logic [1:0]    isel_q;
  logic [IW-1:0] part_q [3];
  logic [IW-1:0] dif_q  [3];  // d5-d7, d6-d2, d1-d3
  logic [IW-1:0] s01_q, s02_q, s12_q;

  always_comb begin
    for (int n = 0; n < 9; n++) begin
      d[n] = IW'($signed(mat_i[n]));
    end
    isel_d = 2'd0;
    if ($signed(d[4]) > $signed(d[0])) begin
      isel_d = 2'd1;
    end
    if ($signed(d[8]) > $signed((isel_d == 2'd1) ? d[4] : d[0])) begin
      isel_d = 2'd2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      trace_q   <= rmq_pkg::sat_add(rmq_pkg::sat_add(d[0], d[4]), d[8]);
      isel_q    <= isel_d;
      part_q[0] <= rmq_pkg::sat_add(rmq_pkg::sat_add(d[0], rmq_pkg::sat_neg(d[4])),
                                    rmq_pkg::sat_neg(d[8]));
      part_q[1] <= rmq_pkg::sat_add(rmq_pkg::sat_add(d[4], rmq_pkg::sat_neg(d[8])),
                                    rmq_pkg::sat_neg(d[0]));
      part_q[2] <= rmq_pkg::sat_add(rmq_pkg::sat_add(d[8], rmq_pkg::sat_neg(d[0])),
                                    rmq_pkg::sat_neg(d[4]));
      dif_q[0]  <= rmq_pkg::sat_add(d[5], rmq_pkg::sat_neg(d[7]));
      dif_q[1]  <= rmq_pkg::sat_add(d[6], rmq_pkg::sat_neg(d[2]));
      dif_q[2]  <= rmq_pkg::sat_add(d[1], rmq_pkg::sat_neg(d[3]));
      s01_q     <= rmq_pkg::sat_add(d[1], d[3]);
      s02_q     <= rmq_pkg::sat_add(d[2], d[6]);
      s12_q     <= rmq_pkg::sat_add(d[5], d[7]);
    end
  end

  // stage 2
  logic                   pos;
  logic [IW-1:0]          arg;
  logic [IW-1:0]          num [3];
  rmq_pkg::side_t         side_d;
  logic                   vld2_q;
  logic [IW-1:0]          rad_q;
  rmq_pkg::side_t         side_q;

  always_comb begin
    pos = ($signed(trace_q) > 0);
    side_d.ctl.degen = 1'b0;
    if (pos) begin
      arg = rmq_pkg::sat_add(trace_q, ONE);
      side_d.ctl.big = rmq_pkg::SLOT_W;
      num[0] = dif_q[0];
      num[1] = dif_q[1];
      num[2] = dif_q[2];
    end else begin
      arg = rmq_pkg::sat_add(part_q[isel_q], ONE);
      side_d.ctl.degen = ($signed(arg) <= 0);
      unique case (isel_q)
        2'd0: begin
          side_d.ctl.big = rmq_pkg::SLOT_X;
          num[0] = s01_q; num[1] = s02_q; num[2] = dif_q[0];
        end
        2'd1: begin
          side_d.ctl.big = rmq_pkg::SLOT_Y;
          num[0] = s01_q; num[1] = s12_q; num[2] = dif_q[1];
        end
        default: begin
          side_d.ctl.big = rmq_pkg::SLOT_Z;
          num[0] = s02_q; num[1] = s12_q; num[2] = dif_q[2];
        end
      endcase
    end
    for (int l = 0; l < 3; l++) begin
      side_d.ctl.neg[l] = num[l][IW-1];
      side_d.mag[l]     = rmq_pkg::sat_shl(rmq_pkg::magnitude(num[l]), SH);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rmq_pkg::sat_shl(arg, SH);
      side_q <= side_d;
    end
  end

  assign valid_o = vld2_q;
  assign rad_o   = rad_q;
  assign side_o  = side_q;

endmodule
`default_nettype wire

// ----- rtl/rmq_isqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_isqrt: pipelined integer square root
// Restoring bit-pair method, one result bit per register stage.
// ----------------------------------------------------------------------------
module rmq_isqrt (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       en_i,
  input  wire                       valid_i,
  input  wire  [rmq_pkg::IW-1:0]    rad_i,
  input  rmq_pkg::side_t            side_i,
  output logic                      valid_o,
  output logic [rmq_pkg::RW-1:0]    root_o,
  output rmq_pkg::side_t            side_o
);

  localparam int unsigned IW = rmq_pkg::IW;
  localparam int unsigned RW = rmq_pkg::RW;

  logic                 vld_q  [RW];
  logic [RW+1:0]        rem_q  [RW];
  logic [RW-1:0]        root_q [RW];
  logic [IW-1:0]        rn_q   [RW];
  rmq_pkg::side_t       side_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic           vld_c;
    logic [RW+1:0]  rem_c;
    logic [RW-1:0]  root_c;
    logic [IW-1:0]  rn_c;
    rmq_pkg::side_t side_c;
    logic [RW+3:0]  rem_sh;
    logic [RW+3:0]  trial;

    if (k == 0) begin : g_first
      assign vld_c  = valid_i;
      assign rem_c  = '0;
      assign root_c = '0;
      assign rn_c   = rad_i;
      assign side_c = side_i;
    end else begin : g_next
      assign vld_c  = vld_q[k-1];
      assign rem_c  = rem_q[k-1];
      assign root_c = root_q[k-1];
      assign rn_c   = rn_q[k-1];
      assign side_c = side_q[k-1];
    end

    assign rem_sh = {rem_c, rn_c[IW-1:IW-2]};
    assign trial  = {2'b00, root_c, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_sh >= trial) begin
          rem_q[k]  <= (RW+2)'(rem_sh - trial);
          root_q[k] <= {root_c[RW-2:0], 1'b1};
        end else begin
          rem_q[k]  <= rem_sh[RW+1:0];
          root_q[k] <= {root_c[RW-2:0], 1'b0};
        end
        rn_q[k]   <= {rn_c[IW-3:0], 2'b00};
        side_q[k] <= side_c;
      end
    end
  end

  assign valid_o = vld_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign side_o  = side_q[RW-1];

endmodule
`default_nettype wire

// ----- rtl/rmq_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_div: three-lane pipelined restoring divider
// Divides each scaled numerator by the root, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rmq_div (
  input  wire                                           clk_i,
  input  wire                                           rst_ni,
  input  wire                                           en_i,
  input  wire                                           valid_i,
  input  wire  [rmq_pkg::RW-1:0]                        root_i,
  input  rmq_pkg::side_t                                side_i,
  output logic                                          valid_o,
  output logic [rmq_pkg::RW-1:0]                        root_o,
  output logic [rmq_pkg::NUM_LANES-1:0][rmq_pkg::IW-1:0] quot_o,
  output rmq_pkg::ctl_t                                 ctl_o
);

  localparam int unsigned IW = rmq_pkg::IW;
  localparam int unsigned RW = rmq_pkg::RW;
  localparam int unsigned NL = rmq_pkg::NUM_LANES;

  logic                      vld_q  [IW];
  logic [RW-1:0]             root_q [IW];
  rmq_pkg::ctl_t             ctl_q  [IW];
  logic [NL-1:0][RW-1:0]     rem_q  [IW];
  logic [NL-1:0][IW-1:0]     qn_q   [IW];

  for (genvar k = 0; k < IW; k++) begin : g_stage
    logic                  vld_c;
    logic [RW-1:0]         root_c;
    rmq_pkg::ctl_t         ctl_c;
    logic [NL-1:0][RW-1:0] rem_c;
    logic [NL-1:0][IW-1:0] qn_c;
    logic [NL-1:0][RW-1:0] rem_d;
    logic [NL-1:0][IW-1:0] qn_d;

    if (k == 0) begin : g_first
      assign vld_c  = valid_i;
      assign root_c = root_i;
      assign ctl_c  = side_i.ctl;
      assign rem_c  = '0;
      assign qn_c   = side_i.mag;
    end else begin : g_next
      assign vld_c  = vld_q[k-1];
      assign root_c = root_q[k-1];
      assign ctl_c  = ctl_q[k-1];
      assign rem_c  = rem_q[k-1];
      assign qn_c   = qn_q[k-1];
    end

    always_comb begin
      logic [RW:0] rs;
      for (int l = 0; l < NL; l++) begin
        rs = {rem_c[l], qn_c[l][IW-1]};
        if (rs >= {1'b0, root_c}) begin
          rem_d[l] = RW'(rs - {1'b0, root_c});
          qn_d[l]  = {qn_c[l][IW-2:0], 1'b1};
        end else begin
          rem_d[l] = rs[RW-1:0];
          qn_d[l]  = {qn_c[l][IW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= root_c;
        ctl_q[k]  <= ctl_c;
        rem_q[k]  <= rem_d;
        qn_q[k]   <= qn_d;
      end
    end
  end

  assign valid_o = vld_q[IW-1];
  assign root_o  = root_q[IW-1];
  assign quot_o  = qn_q[IW-1];
  assign ctl_o   = ctl_q[IW-1];

endmodule
`default_nettype wire

// ----- rtl/rmq_pack.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_pack: saturation, slot routing and output register
// Places the root and the three signed quotients in x, y, z, w; all zero if degenerate.
// ----------------------------------------------------------------------------
module rmq_pack #(
  parameter int unsigned WORD_WIDTH = 32
) (
  input  wire                                           clk_i,
  input  wire                                           rst_ni,
  input  wire                                           en_i,
  input  wire                                           valid_i,
  input  wire  [rmq_pkg::RW-1:0]                        root_i,
  input  wire  [rmq_pkg::NUM_LANES-1:0][rmq_pkg::IW-1:0] quot_i,
  input  rmq_pkg::ctl_t                                 ctl_i,
  output logic                                          valid_o,
  output logic [3:0][WORD_WIDTH-1:0]                    q_o,
  output logic                                          degen_o
);

  localparam int unsigned IW = rmq_pkg::IW;
  localparam logic [IW-1:0] LIM =
    ({{(IW-1){1'b0}}, 1'b1} << (WORD_WIDTH - 1)) - {{(IW-1){1'b0}}, 1'b1};

  function automatic logic [WORD_WIDTH-1:0] sat_word(input logic [IW-1:0] mag,
                                                     input logic neg);
    logic [IW-1:0] m;
    m = mag;
    if (neg) begin
      if (m > LIM + {{(IW-1){1'b0}}, 1'b1}) begin
        m = LIM + {{(IW-1){1'b0}}, 1'b1};
      end
      m = ~m + {{(IW-1){1'b0}}, 1'b1};
    end else if (m > LIM) begin
      m = LIM;
    end
    return m[WORD_WIDTH-1:0];
  endfunction

  logic [3:0][WORD_WIDTH-1:0] q_d;
  logic                       vld_q;
  logic [3:0][WORD_WIDTH-1:0] q_q;
  logic                       degen_q;

  always_comb begin
    logic [1:0] lane;
    for (int s = 0; s < 4; s++) begin
      lane = (2'(s) > ctl_i.big) ? 2'(s - 1) : 2'(s);
      if (ctl_i.degen) begin
        q_d[s] = '0;
      end else if (2'(s) == ctl_i.big) begin
        q_d[s] = sat_word(IW'(root_i), 1'b0);
      end else begin
        q_d[s] = sat_word(quot_i[lane], ctl_i.neg[lane]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q     <= q_d;
      degen_q <= ctl_i.degen;
    end
  end

  assign valid_o = vld_q;
  assign q_o     = q_q;
  assign degen_o = degen_q;

endmodule
`default_nettype wire

// ----- bench/rotation_matrix_to_quaternion_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: self-checking testbench
// Drives Q2.30 matrices through the valid/stall input channel, predicts each
// quaternion in fixed point alongside the pipeline and compares every
// transaction that leaves the output channel, under random input gaps and
// output stalls.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_test;

  localparam int unsigned WW        = 32;
  localparam int unsigned FB        = 30;
  localparam longint      ONE       = 64'sd1 << FB;
  localparam int          LATENCY   = 99;
  localparam int          CYCLE_CAP = 400000;

  typedef logic [WW-1:0] matrix_t [9];

  typedef struct {
    logic [WW-1:0] qx;
    logic [WW-1:0] qy;
    logic [WW-1:0] qz;
    logic [WW-1:0] qw;
    logic          degen;
  } quat_t;

  logic          clk_i;
  logic          rst_ni;
  logic          valid_i;
  logic          stall_o;
  logic [WW-1:0] m_i [9];
  logic          valid_o;
  logic          stall_i;
  logic [WW-1:0] qx_o, qy_o, qz_o, qw_o;
  logic          degenerate_o;

  quat_t pending_quats [$];
  int    err_count;
  int    cycle_count;
  bit    quiet_in;
  bit    quiet_out;

  rotation_matrix_to_quaternion #(
    .WORD_WIDTH(WW),
    .FRAC_BITS (FB)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_i),
    .stall_o     (stall_o),
    .m_0_i       (m_i[0]),
    .m_1_i       (m_i[1]),
    .m_2_i       (m_i[2]),
    .m_3_i       (m_i[3]),
    .m_4_i       (m_i[4]),
    .m_5_i       (m_i[5]),
    .m_6_i       (m_i[6]),
    .m_7_i       (m_i[7]),
    .m_8_i       (m_i[8]),
    .valid_o     (valid_o),
    .stall_i     (stall_i),
    .qx_o        (qx_o),
    .qy_o        (qy_o),
    .qz_o        (qz_o),
    .qw_o        (qw_o),
    .degenerate_o(degenerate_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // ---- fixed-point predictor ----

  function automatic longint unsigned root64(input longint unsigned n);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [WW-1:0] clamp_word(input longint unsigned mag, input bit neg);
    longint unsigned lim;
    lim = (64'd1 << (WW - 1)) - 1;
    if (neg) begin
      if (mag > lim + 1) mag = lim + 1;
      return WW'(64'd0 - mag);
    end
    if (mag > lim) mag = lim;
    return WW'(mag);
  endfunction

  // Sums of 32-bit words never leave the 64-bit range, so plain arithmetic holds.
  function automatic logic [WW-1:0] scaled_quot(input longint num, input longint unsigned den);
    longint unsigned mag;
    mag = (num < 0) ? longint'(-num) : num;
    return clamp_word((mag << (FB - 2)) / den, num < 0);
  endfunction

  function automatic quat_t predict_quaternion(input matrix_t m);
    longint          d [9];
    logic [WW-1:0]   q [4];
    longint          trace, arg;
    longint unsigned c;
    int              i, j, k;
    quat_t           r;
    for (int n = 0; n < 9; n++) d[n] = longint'(signed'(m[n]));
    for (int n = 0; n < 4; n++) q[n] = '0;
    r.degen = 1'b0;
    trace = d[0] + d[4] + d[8];
    if (trace > 0) begin
      c    = root64(longint'(trace + ONE) << (FB - 2));
      q[3] = clamp_word(c, 1'b0);
      q[0] = scaled_quot(d[5] - d[7], c);
      q[1] = scaled_quot(d[6] - d[2], c);
      q[2] = scaled_quot(d[1] - d[3], c);
    end else begin
      // pick the largest diagonal, lower index on ties
      i = 0;
      if (d[4] > d[0]) i = 1;
      if (d[8] > d[i*3+i]) i = 2;
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      arg = d[i*3+i] - d[j*3+j] - d[k*3+k] + ONE;
      if (arg <= 0) begin
        r.degen = 1'b1;
      end else begin
        c    = root64(longint'(arg) << (FB - 2));
        q[i] = clamp_word(c, 1'b0);
        q[3] = scaled_quot(d[j*3+k] - d[k*3+j], c);
        q[j] = scaled_quot(d[j*3+i] + d[i*3+j], c);
        q[k] = scaled_quot(d[k*3+i] + d[i*3+k], c);
      end
    end
    r.qx = q[0];
    r.qy = q[1];
    r.qz = q[2];
    r.qw = q[3];
    return r;
  endfunction

  // ---- input side ----

  function automatic int pick_gap();
    if (quiet_in || $urandom_range(0, 2) != 0) return 0;
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  task automatic send_matrix(input matrix_t m);
    int    gap;
    bit    held;
    quat_t expq;
    gap  = pick_gap();
    expq = predict_quaternion(m);
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    for (int n = 0; n < 9; n++) m_i[n] <= m[n];
    // hold the payload until the transaction is taken
    do begin
      @(negedge clk_i);
      held = stall_o;
      @(posedge clk_i);
    end while (held);
    pending_quats.push_back(expq);
  endtask

  function automatic logic [WW-1:0] to_fixed(input real v);
    return WW'($rtoi(v * 1073741824.0));
  endfunction

  // Rotation built from a unit quaternion, optionally nudged.
  function automatic matrix_t rotation_from_quat(input real x, input real y, input real z,
                                                 input real w, input int jitter);
    matrix_t m;
    real     r [9];
    r[0] = 1.0 - 2.0 * (y*y + z*z);
    r[1] = 2.0 * (x*y + z*w);
    r[2] = 2.0 * (x*z - y*w);
    r[3] = 2.0 * (x*y - z*w);
    r[4] = 1.0 - 2.0 * (x*x + z*z);
    r[5] = 2.0 * (y*z + x*w);
    r[6] = 2.0 * (x*z + y*w);
    r[7] = 2.0 * (y*z - x*w);
    r[8] = 1.0 - 2.0 * (x*x + y*y);
    for (int n = 0; n < 9; n++)
      m[n] = to_fixed(r[n]) + WW'($urandom_range(0, 2 * jitter) - jitter);
    return m;
  endfunction

  function automatic real rand_unit();
    return (real'($urandom_range(0, 2000000)) - 1000000.0) / 1000000.0;
  endfunction

  function automatic matrix_t random_rotation(input int jitter);
    real x, y, z, w, nrm;
    do begin
      x   = rand_unit();
      y   = rand_unit();
      z   = rand_unit();
      w   = rand_unit();
      nrm = $sqrt(x*x + y*y + z*z + w*w);
    end while (nrm < 0.05);
    return rotation_from_quat(x / nrm, y / nrm, z / nrm, w / nrm, jitter);
  endfunction

  // ---- output side ----

  int out_hold;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_i  <= 1'b0;
      out_hold <= 0;
    end else if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      stall_i  <= 1'b1;
    end else if (!quiet_out && $urandom_range(0, 3) == 0) begin
      stall_i  <= 1'b1;
      out_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end else begin
      stall_i <= 1'b0;
    end
  end

  // Inputs only move at the rising edge, so the values seen here are the ones taken.
  always @(negedge clk_i) begin
    quat_t expq;
    if (rst_ni && valid_o && !stall_i) begin
      if (pending_quats.size() == 0) begin
        $error("unexpected result transaction");
        err_count++;
      end else begin
        expq = pending_quats.pop_front();
        if (qx_o !== expq.qx) begin
          $error("qx: expected %h, got %h", expq.qx, qx_o);
          err_count++;
        end
        if (qy_o !== expq.qy) begin
          $error("qy: expected %h, got %h", expq.qy, qy_o);
          err_count++;
        end
        if (qz_o !== expq.qz) begin
          $error("qz: expected %h, got %h", expq.qz, qz_o);
          err_count++;
        end
        if (qw_o !== expq.qw) begin
          $error("qw: expected %h, got %h", expq.qw, qw_o);
          err_count++;
        end
        if (degenerate_o !== expq.degen) begin
          $error("degenerate: expected %b, got %b", expq.degen, degenerate_o);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("[rotation_matrix_to_quaternion] ERROR");
      $finish;
    end
  end

  // ---- tests ----

  task automatic test_directed();
    matrix_t m;
    logic [WW-1:0] pos_one, neg_one;
    pos_one = WW'(ONE);
    neg_one = WW'(-ONE);
    // identity
    m = '{pos_one, 0, 0, 0, pos_one, 0, 0, 0, pos_one};
    send_matrix(m);
    // half turns about each axis: trace negative, each diagonal wins once
    m = '{pos_one, 0, 0, 0, neg_one, 0, 0, 0, neg_one};
    send_matrix(m);
    m = '{neg_one, 0, 0, 0, pos_one, 0, 0, 0, neg_one};
    send_matrix(m);
    m = '{neg_one, 0, 0, 0, neg_one, 0, 0, 0, pos_one};
    send_matrix(m);
    // zero or negative trace and equal diagonals: ties go to the lower index
    m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_matrix(m);
    m = '{neg_one, 0, 0, 0, neg_one, 0, 0, 0, neg_one};
    send_matrix(m);
    m = '{0, 32'h1234_5678, 0, 0, 0, 32'h8765_4321, 0, 0, 0};
    send_matrix(m);
    // word extremes in every matrix element
    for (int n = 0; n < 9; n++) m[n] = 32'h7fff_ffff;
    send_matrix(m);
    for (int n = 0; n < 9; n++) m[n] = 32'h8000_0000;
    send_matrix(m);
    m = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
          32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
    send_matrix(m);
    m = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
          32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000};
    send_matrix(m);
    // smallest positive trace and its neighbours
    m = '{1, 0, 0, 0, 0, 0, 0, 0, 0};
    send_matrix(m);
    m = '{32'hffff_ffff, 0, 0, 0, 0, 0, 0, 0, 1};
    send_matrix(m);
    m = '{0, 0, 0, 0, 32'hffff_ffff, 0, 0, 0, 32'hffff_ffff};
    send_matrix(m);
    // half turn about a skew axis, then a partial turn about x with positive trace
    m = rotation_from_quat(0.0, 0.6, 0.8, 0.0, 0);
    send_matrix(m);
    m = rotation_from_quat(0.8, 0.0, 0.0, 0.6, 0);
    send_matrix(m);
  endtask

  task automatic test_rotations(input int count);
    for (int t = 0; t < count; t++)
      send_matrix(random_rotation(($urandom_range(0, 3) == 0) ? 64 : 0));
  endtask

  task automatic test_raw_words(input int count);
    matrix_t m;
    for (int t = 0; t < count; t++) begin
      for (int n = 0; n < 9; n++) m[n] = $urandom();
      send_matrix(m);
    end
  endtask

  // Diagonals pulled from a few values so ties and sign flips of the trace recur.
  task automatic test_diagonal_ties(input int count);
    matrix_t       m;
    logic [WW-1:0] pool [6];
    pool = '{0, WW'(ONE), WW'(-ONE), 1, 32'hffff_ffff, WW'(ONE / 2)};
    for (int t = 0; t < count; t++) begin
      for (int n = 0; n < 9; n++) m[n] = $urandom() >> $urandom_range(0, 31);
      m[0] = pool[$urandom_range(0, 5)];
      m[4] = pool[$urandom_range(0, 5)];
      m[8] = pool[$urandom_range(0, 5)];
      send_matrix(m);
    end
  endtask

  task automatic test_back_to_back(input int count);
    quiet_in  = 1'b1;
    quiet_out = 1'b1;
    test_rotations(count);
    quiet_in  = 1'b0;
    test_rotations(count);
    quiet_in  = 1'b1;
    quiet_out = 1'b0;
    test_raw_words(count);
    quiet_in  = 1'b0;
  endtask

  initial begin
    int drain;
    rst_ni      = 1'b0;
    valid_i     = 1'b0;
    err_count   = 0;
    cycle_count = 0;
    quiet_in    = 1'b0;
    quiet_out   = 1'b0;
    for (int n = 0; n < 9; n++) m_i[n] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_rotations(250);
    test_raw_words(120);
    test_diagonal_ties(80);
    test_back_to_back(30);

    valid_i <= 1'b0;
    drain = 0;
    while (pending_quats.size() != 0 && drain < 20000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (2 * LATENCY) @(posedge clk_i);
    if (err_count == 0 && pending_quats.size() == 0) begin
      $display("[rotation_matrix_to_quaternion] OK");
    end else begin
      $display("[rotation_matrix_to_quaternion] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/rmq_pkg.sv
rtl/rmq_prep.sv
rtl/rmq_isqrt.sv
rtl/rmq_div.sv
rtl/rmq_pack.sv
rtl/rotation_matrix_to_quaternion.sv
bench/rotation_matrix_to_quaternion_test.sv
